@@ rtl/bps_pkg.sv @@
// shared types and constants for the box prefiltered bilinear scaler
// no dependencies; used by every module of the scaler except bps_div
package bps_pkg;

    // defaults for the top level parameters
    localparam int unsigned DEF_MAX_WIDTH  = 512;
    localparam int unsigned DEF_MAX_HEIGHT = 512;
    localparam int unsigned DEF_FRAC_BITS  = 8;

    // fixed field widths
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned COORD_W    = 9;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CHAN_CFG_W = 3;

    // register reset values and the rgba channel code
    localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 10'd128;
    localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 10'd128;
    localparam logic [CFG_DATA_W-1:0] RST_DST_WIDTH  = 10'd512;
    localparam logic [CFG_DATA_W-1:0] RST_DST_HEIGHT = 10'd512;
    localparam logic [CHAN_CFG_W-1:0] RST_CHANNELS   = 3'd3;
    localparam logic [CHAN_CFG_W-1:0] CHAN_RGBA      = 3'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_CHANNELS   = 3'd4
    } t_cfg_idx;

    // which quotient the shared divider works on
    typedef enum logic [2:0] {
        DIV_FX  = 3'd0,
        DIV_FY  = 3'd1,
        DIV_EW  = 3'd2,
        DIV_EH  = 3'd3,
        DIV_PX  = 3'd4,
        DIV_PY  = 3'd5,
        DIV_BOX = 3'd6
    } t_div_sel;

    // lerp sub-steps for one channel
    typedef enum logic [1:0] {
        LERP_TOP  = 2'd0,
        LERP_BOT  = 2'd1,
        LERP_VERT = 2'd2
    } t_lerp_step;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        t_div_sel   dsel;
        logic       div_start;
        logic       div_load;
        logic [1:0] tap;
        logic [1:0] chan;
        logic       tap_set;
        logic       fetch;
        t_lerp_step lstep;
        logic       lerp;
        logic       out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic oor;
        logic div_done;
        logic f_big;
        logic fetch_last;
        logic out_busy;
    } t_status;

    function automatic int unsigned max2(input int unsigned a, input int unsigned b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/bps_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on nothing
module bps_div #(
    parameter int unsigned NUM_W = 16,
    parameter int unsigned DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    // one trial subtract
    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/bps_datapath.sv @@
// datapath: registers, frame store, box sums, divider, lerp unit, output register
// depends on bps_pkg and bps_div
module bps_datapath
    import bps_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_op,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  logic [PIX_W-1:0]      i_alpha_in,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_red_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic [PIX_W-1:0]      o_alpha_out,
    output logic                  o_out_of_range
);
    localparam int unsigned MAXD  = max2(MAX_WIDTH, MAX_HEIGHT);
    localparam int unsigned SZW   = $clog2(MAXD + 1);
    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNTW  = 2 * SZW;
    localparam int unsigned SUMW  = PIX_W + CNTW;
    localparam int unsigned PMW   = CFG_DATA_W + SZW;
    localparam int unsigned PNW   = PMW + FRAC_BITS;
    localparam int unsigned PW    = SZW + FRAC_BITS;
    localparam int unsigned DVN   = max2(SUMW + 1, PNW);
    localparam int unsigned DVD   = max2(CNTW, CFG_DATA_W + 1);
    localparam int unsigned LVW   = PIX_W + FRAC_BITS + 2;
    localparam int unsigned ONE   = 2 ** FRAC_BITS;
    localparam int unsigned HALF  = 2 ** (FRAC_BITS - 1);

    // configuration registers
    logic [CFG_DATA_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [CHAN_CFG_W-1:0] r_chan_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= RST_SRC_WIDTH;
            r_src_h    <= RST_SRC_HEIGHT;
            r_dst_w    <= RST_DST_WIDTH;
            r_dst_h    <= RST_DST_HEIGHT;
            r_chan_cfg <= RST_CHANNELS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_w    <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h    <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w    <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h    <= i_cfg_data;
                CFG_CHANNELS:   r_chan_cfg <= i_cfg_data[CHAN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [SZW-1:0]        sw, sh;
    logic [CFG_DATA_W-1:0] dw, dh;

    always_comb begin
        if (r_src_w == '0)
            sw = SZW'(1);
        else if (32'(r_src_w) > MAX_WIDTH)
            sw = SZW'(MAX_WIDTH);
        else
            sw = SZW'(r_src_w);
        if (r_src_h == '0)
            sh = SZW'(1);
        else if (32'(r_src_h) > MAX_HEIGHT)
            sh = SZW'(MAX_HEIGHT);
        else
            sh = SZW'(r_src_h);
        dw = (r_dst_w == '0) ? CFG_DATA_W'(1) : r_dst_w;
        dh = (r_dst_h == '0) ? CFG_DATA_W'(1) : r_dst_h;
    end

    // captured request
    logic [COORD_W-1:0] r_col, r_row;
    logic               r_oor;
    logic               in_oor;

    assign in_oor = ({1'b0, i_col} >= dw) || ({1'b0, i_row} >= dh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col <= i_col;
            r_row <= i_row;
            r_oor <= in_oor;
        end
    end

    // frame store
    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_rd;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [XW-1:0] r_xs;
    logic [YW-1:0] r_ys;
    logic [SZW-1:0] r_i, r_j;

    assign wr_en   = i_cmd.accept && !i_op && (32'(i_col) < 32'(sw)) && (32'(i_row) < 32'(sh));
    assign wr_addr = AW'(32'(i_row) * MAX_WIDTH + 32'(i_col));
    assign rd_addr = AW'((32'(r_ys) + 32'(r_j)) * MAX_WIDTH + 32'(r_xs) + 32'(r_i));

    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[wr_addr] <= {i_alpha_in, i_blue_in, i_green_in, i_red_in};
        if (i_cmd.fetch)
            r_rd <= mem[rd_addr];
    end

    // factor and effective sizes
    logic [SZW-1:0]  r_fx, r_fe, r_ew, r_eh;
    logic            r_fbig;
    logic [CNTW-1:0] r_cnt;
    logic [PW-1:0]   r_px, r_py;

    always_ff @(posedge i_clk) begin
        r_cnt <= CNTW'(r_fe) * CNTW'(r_fe);
    end

    // tap coordinates
    logic [SZW-1:0]   x0, y0, x1, y1, ex, ey;
    logic [SZW:0]     x0p, y0p;
    logic [FRAC_BITS-1:0] tx, ty;

    always_comb begin
        x0  = r_px[PW-1:FRAC_BITS];
        y0  = r_py[PW-1:FRAC_BITS];
        tx  = r_px[FRAC_BITS-1:0];
        ty  = r_py[FRAC_BITS-1:0];
        x0p = {1'b0, x0} + (SZW + 1)'(1);
        y0p = {1'b0, y0} + (SZW + 1)'(1);
        x1  = (x0p < {1'b0, r_ew}) ? x0p[SZW-1:0] : r_ew - SZW'(1);
        y1  = (y0p < {1'b0, r_eh}) ? y0p[SZW-1:0] : r_eh - SZW'(1);
        ex  = i_cmd.tap[0] ? x1 : x0;
        ey  = i_cmd.tap[1] ? y1 : y0;
    end

    // box window walk
    logic fetch_last;

    assign fetch_last = (r_i == r_fe - SZW'(1)) && (r_j == r_fe - SZW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_set) begin
            r_xs <= XW'(CNTW'(ex) * CNTW'(r_fe));
            r_ys <= YW'(CNTW'(ey) * CNTW'(r_fe));
            r_i  <= '0;
            r_j  <= '0;
        end else if (i_cmd.fetch) begin
            if (r_i == r_fe - SZW'(1)) begin
                r_i <= '0;
                r_j <= r_j + SZW'(1);
            end else begin
                r_i <= r_i + SZW'(1);
            end
        end
    end

    // channel sums, accumulated from the registered read word r_rd under the delayed fetch flag r_acc_v
    logic            r_acc_v;
    logic [SUMW-1:0] r_sum [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_acc_v <= 1'b0;
        else
            r_acc_v <= i_cmd.fetch;
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (i_cmd.tap_set)
                r_sum[c] <= '0;
            else if (r_acc_v)
                r_sum[c] <= r_sum[c] + SUMW'(r_rd[8*c +: 8]);
        end
    end

    // divider operand select
    logic [CFG_DATA_W-1:0] pm_a;
    logic [SZW-1:0]        pm_b;
    logic [PMW-1:0]        pmul;
    logic [DVN-1:0]        div_num;
    logic [DVD-1:0]        div_den;
    logic                  div_done;
    logic [DVN-1:0]        div_q;

    always_comb begin
        pm_a = (i_cmd.dsel == DIV_PY) ? {r_row, 1'b1} : {r_col, 1'b1};
        pm_b = (i_cmd.dsel == DIV_PY) ? r_eh : r_ew;
        pmul = PMW'(pm_a) * PMW'(pm_b);
        case (i_cmd.dsel)
            DIV_FX: begin
                div_num = DVN'(sw);
                div_den = DVD'(dw);
            end
            DIV_FY: begin
                div_num = DVN'(sh);
                div_den = DVD'(dh);
            end
            DIV_EW: begin
                div_num = DVN'(sw);
                div_den = DVD'(r_fe);
            end
            DIV_EH: begin
                div_num = DVN'(sh);
                div_den = DVD'(r_fe);
            end
            DIV_PX: begin
                div_num = DVN'({pmul, {FRAC_BITS{1'b0}}});
                div_den = DVD'({dw, 1'b0});
            end
            DIV_PY: begin
                div_num = DVN'({pmul, {FRAC_BITS{1'b0}}});
                div_den = DVD'({dh, 1'b0});
            end
            DIV_BOX: begin
                div_num = DVN'(r_sum[i_cmd.chan]) + DVN'(r_cnt >> 1);
                div_den = DVD'(r_cnt);
            end
            default: begin
                div_num = '0;
                div_den = DVD'(1);
            end
        endcase
    end

    bps_div #(
        .NUM_W (DVN),
        .DEN_W (DVD)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // centre aligned position, shifted by half a pixel and clamped
    function automatic logic [PW-1:0] clamp_pos(input logic [DVN-1:0] q,
                                                 input logic [SZW-1:0] s);
        logic [DVN-1:0] p;
        logic [DVN-1:0] top;
        p   = (q > DVN'(HALF)) ? q - DVN'(HALF) : '0;
        top = DVN'(s - SZW'(1)) << FRAC_BITS;
        if (p > top)
            p = top;
        return PW'(p);
    endfunction

    // quotient write back
    logic [SZW-1:0]   q_sz;
    logic [SZW-1:0]   f_min;
    logic [PIX_W-1:0] r_pix [4][4];

    assign q_sz  = SZW'(div_q);
    assign f_min = (r_fx < q_sz) ? r_fx : q_sz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            case (i_cmd.dsel)
                DIV_FX: r_fx <= q_sz;
                DIV_FY: begin
                    r_fbig <= f_min >= SZW'(2);
                    r_fe   <= (f_min >= SZW'(2)) ? f_min : SZW'(1);
                    r_ew   <= sw;
                    r_eh   <= sh;
                end
                DIV_EW:  r_ew <= (q_sz == '0) ? SZW'(1) : q_sz;
                DIV_EH:  r_eh <= (q_sz == '0) ? SZW'(1) : q_sz;
                DIV_PX:  r_px <= clamp_pos(div_q, r_ew);
                DIV_PY:  r_py <= clamp_pos(div_q, r_eh);
                DIV_BOX: r_pix[i_cmd.tap][i_cmd.chan] <= div_q[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // lerp unit, one step per cycle
    logic [PIX_W-1:0]     la, lb, lres;
    logic [FRAC_BITS-1:0] lt;
    logic [LVW-1:0]       lv;
    logic [PIX_W-1:0]     r_top, r_bot;
    logic [PIX_W-1:0]     r_res [4];

    always_comb begin
        case (i_cmd.lstep)
            LERP_TOP: begin
                la = r_pix[0][i_cmd.chan];
                lb = r_pix[1][i_cmd.chan];
                lt = tx;
            end
            LERP_BOT: begin
                la = r_pix[2][i_cmd.chan];
                lb = r_pix[3][i_cmd.chan];
                lt = tx;
            end
            default: begin
                la = r_top;
                lb = r_bot;
                lt = ty;
            end
        endcase
        lv   = LVW'(la) * (LVW'(ONE) - LVW'(lt)) + LVW'(lb) * LVW'(lt) + LVW'(HALF);
        lres = lv[FRAC_BITS +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lerp) begin
            case (i_cmd.lstep)
                LERP_TOP: r_top <= lres;
                LERP_BOT: r_bot <= lres;
                default:  r_res[i_cmd.chan] <= lres;
            endcase
        end
    end

    // output register
    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (i_cmd.out_load)
            r_ov <= 1'b1;
        else if (i_out_ready)
            r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_red_out      <= r_oor ? '0 : r_res[0];
            o_green_out    <= r_oor ? '0 : r_res[1];
            o_blue_out     <= r_oor ? '0 : r_res[2];
            o_alpha_out    <= (r_oor || r_chan_cfg != CHAN_RGBA) ? '0 : r_res[3];
            o_out_of_range <= r_oor;
        end
    end

    assign o_valid = r_ov;

    // status back to the controller
    always_comb begin
        o_status.is_read    = i_op;
        o_status.oor        = in_oor;
        o_status.div_done   = div_done;
        o_status.f_big      = r_fbig;
        o_status.fetch_last = fetch_last;
        o_status.out_busy   = r_ov && !i_out_ready;
    end

endmodule

@@ rtl/bps_ctrl.sv @@
// controller state machine sequencing the scaler datapath
// depends on bps_pkg
module bps_ctrl
    import bps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DSTART = 9'b000000010,
        S_DWAIT  = 9'b000000100,
        S_FCHK   = 9'b000001000,
        S_TAPSET = 9'b000010000,
        S_FETCH  = 9'b000100000,
        S_DRAIN  = 9'b001000000,
        S_LERP   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    t_div_sel   r_dsel, n_dsel;
    logic [1:0] r_tap, n_tap;
    logic [1:0] r_chan, n_chan;
    t_lerp_step r_step, n_step;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_dsel  = r_dsel;
        n_tap   = r_tap;
        n_chan  = r_chan;
        n_step  = r_step;
        o_ready = 1'b0;
        o_cmd           = '0;
        o_cmd.dsel      = r_dsel;
        o_cmd.tap       = r_tap;
        o_cmd.chan      = r_chan;
        o_cmd.lstep     = r_step;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_read) begin
                        if (i_status.oor) begin
                            n_state = S_OUT;
                        end else begin
                            n_dsel  = DIV_FX;
                            n_state = S_DSTART;
                        end
                    end
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    case (r_dsel)
                        DIV_FX: begin
                            n_dsel  = DIV_FY;
                            n_state = S_DSTART;
                        end
                        DIV_FY: n_state = S_FCHK;
                        DIV_EW: begin
                            n_dsel  = DIV_EH;
                            n_state = S_DSTART;
                        end
                        DIV_EH: begin
                            n_dsel  = DIV_PX;
                            n_state = S_DSTART;
                        end
                        DIV_PX: begin
                            n_dsel  = DIV_PY;
                            n_state = S_DSTART;
                        end
                        DIV_PY: begin
                            n_tap   = 2'd0;
                            n_state = S_TAPSET;
                        end
                        DIV_BOX: begin
                            if (r_chan == 2'd3) begin
                                n_chan = 2'd0;
                                if (r_tap == 2'd3) begin
                                    n_step  = LERP_TOP;
                                    n_state = S_LERP;
                                end else begin
                                    n_tap   = r_tap + 2'd1;
                                    n_state = S_TAPSET;
                                end
                            end else begin
                                n_chan  = r_chan + 2'd1;
                                n_state = S_DSTART;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FCHK: begin
                n_dsel  = i_status.f_big ? DIV_EW : DIV_PX;
                n_state = S_DSTART;
            end
            S_TAPSET: begin
                o_cmd.tap_set = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_status.fetch_last)
                    n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_dsel  = DIV_BOX;
                n_chan  = 2'd0;
                n_state = S_DSTART;
            end
            S_LERP: begin
                o_cmd.lerp = 1'b1;
                case (r_step)
                    LERP_TOP: n_step = LERP_BOT;
                    LERP_BOT: n_step = LERP_VERT;
                    default: begin
                        n_step = LERP_TOP;
                        if (r_chan == 2'd3)
                            n_state = S_OUT;
                        else
                            n_chan = r_chan + 2'd1;
                    end
                endcase
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dsel  <= DIV_FX;
            r_tap   <= 2'd0;
            r_chan  <= 2'd0;
            r_step  <= LERP_TOP;
        end else begin
            r_state <= n_state;
            r_dsel  <= n_dsel;
            r_tap   <= n_tap;
            r_chan  <= n_chan;
            r_step  <= n_step;
        end
    end

endmodule

@@ rtl/box_prefiltered_bilinear_scaler.sv @@
// top level of the box prefiltered bilinear scaler
// depends on bps_pkg, bps_ctrl and bps_datapath (which holds bps_div)

// A store beat (op 0) writes one source pixel into the frame store if it lies inside
// the source; the block is ready again in the next cycle. A read beat (op 1) that
// lies outside the destination goes straight to the output state and is loaded into
// the output register once that register is free. An in-range read runs through one
// shared restoring divider that produces one quotient bit per cycle: D setup
// divisions for the factor and the position (D is 4, or 6 when the box prefilter
// applies and the effective size is divided out too) and a check state to pick the
// path, then for each of the four taps a walk of f*f frame store reads (one per
// cycle), where f is the box factor (1 when no prefilter applies), and four rounding
// divisions, then twelve lerp steps. The divider width is 29 bits at the default
// sizes. The result waits in an output register, loaded once the previous result
// has left it, so the next beat is taken while it waits. The frame store content is
// undefined until written.
module box_prefiltered_bilinear_scaler
    import bps_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  logic [PIX_W-1:0]      i_alpha_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_red_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic [PIX_W-1:0]      o_alpha_out,
    output logic                  o_out_of_range
);
    t_cmd    cmd;
    t_status status;

    // sequencer
    bps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath with frame store and divider
    bps_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_alpha_in     (i_alpha_in),
        .i_out_ready    (i_ready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_alpha_out    (o_alpha_out),
        .o_out_of_range (o_out_of_range)
    );

endmodule

@@ tb/sv/tb_box_prefiltered_bilinear_scaler.sv @@
// self-checking testbench for box_prefiltered_bilinear_scaler
// depends on bps_pkg and the scaler rtl; predicts each read and checks every result beat
`timescale 1ns / 1ps

module tb_box_prefiltered_bilinear_scaler;
    import bps_pkg::*;

    localparam int unsigned STORE_W    = 512;
    localparam int unsigned STORE_H    = 512;
    localparam int unsigned FRAC       = 8;
    localparam int unsigned SETTLE     = 20;
    localparam int unsigned STALL_MAX  = 20000;
    localparam int unsigned HOLD_LEN   = 3000;
    localparam logic        OP_STORE   = 1'b0;
    localparam logic        OP_READ    = 1'b1;

    typedef struct {
        logic       op;
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_cmd_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       oor;
    } scaled_pix_t;

    typedef struct {
        int unsigned f;
        int unsigned x0, x1, y0, y1;
        int unsigned tx, ty;
    } tap_geom_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_op = 1'b0;
    logic [COORD_W-1:0]    i_col = '0;
    logic [COORD_W-1:0]    i_row = '0;
    logic [PIX_W-1:0]      i_red_in = '0;
    logic [PIX_W-1:0]      i_green_in = '0;
    logic [PIX_W-1:0]      i_blue_in = '0;
    logic [PIX_W-1:0]      i_alpha_in = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic [PIX_W-1:0]      o_alpha_out;
    logic                  o_out_of_range;

    box_prefiltered_bilinear_scaler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_op(i_op), .i_col(i_col), .i_row(i_row),
        .i_red_in(i_red_in), .i_green_in(i_green_in), .i_blue_in(i_blue_in),
        .i_alpha_in(i_alpha_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_red_out(o_red_out),
        .o_green_out(o_green_out), .o_blue_out(o_blue_out), .o_alpha_out(o_alpha_out),
        .o_out_of_range(o_out_of_range)
    );

    // shadow registers and frame copy
    int unsigned reg_sw = RST_SRC_WIDTH, reg_sh = RST_SRC_HEIGHT;
    int unsigned reg_dw = RST_DST_WIDTH, reg_dh = RST_DST_HEIGHT;
    int unsigned reg_ch = RST_CHANNELS;
    logic [31:0] frame_copy [0:STORE_W*STORE_H-1];
    bit          planned_written [0:STORE_W*STORE_H-1];

    pixel_cmd_t  pending_cmds[$];
    scaled_pix_t expected_pix[$];
    int unsigned err_cnt = 0;
    int unsigned send_idle_pct = 0, recv_idle_pct = 0;
    int unsigned hold_req_seq = 0, hold_ack_seq = 0, hold_left = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_src(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned axis_pos(int unsigned d, int unsigned s, int unsigned dsz);
        longint unsigned num, q, p, top;
        num = longint'((2 * d + 1) * s) << FRAC;
        q   = num / (2 * longint'(dsz));
        p   = (q > (1 << (FRAC - 1))) ? q - (1 << (FRAC - 1)) : 0;
        top = longint'(s - 1) << FRAC;
        return int'((p > top) ? top : p);
    endfunction

    // tap positions and weights for one destination pixel
    function automatic tap_geom_t locate(int unsigned col, int unsigned row);
        tap_geom_t   g;
        int unsigned sw, sh, dw, dh, ew, eh, px, py;
        sw = eff_src(reg_sw, STORE_W);
        sh = eff_src(reg_sh, STORE_H);
        dw = (reg_dw == 0) ? 1 : reg_dw;
        dh = (reg_dh == 0) ? 1 : reg_dh;
        g.f = ((sw / dw) < (sh / dh)) ? sw / dw : sh / dh;
        ew = sw;
        eh = sh;
        if (g.f >= 2) begin
            ew = (sw / g.f == 0) ? 1 : sw / g.f;
            eh = (sh / g.f == 0) ? 1 : sh / g.f;
        end
        px = axis_pos(col, ew, dw);
        py = axis_pos(row, eh, dh);
        g.x0 = px >> FRAC;
        g.y0 = py >> FRAC;
        g.x1 = (g.x0 + 1 < ew) ? g.x0 + 1 : ew - 1;
        g.y1 = (g.y0 + 1 < eh) ? g.y0 + 1 : eh - 1;
        g.tx = px - (g.x0 << FRAC);
        g.ty = py - (g.y0 << FRAC);
        return g;
    endfunction

    // one channel of an effective pixel, box averaged when f is 2 or more
    function automatic int unsigned box_avg(int unsigned ex, int unsigned ey, int unsigned f,
                                            int unsigned c);
        int unsigned sum, cnt;
        logic [31:0] w;
        if (f < 2) begin
            w = frame_copy[ey * STORE_W + ex];
            return (w >> (8 * c)) & 8'hFF;
        end
        sum = 0;
        for (int j = 0; j < f; j++)
            for (int i = 0; i < f; i++) begin
                w = frame_copy[(ey * f + j) * STORE_W + ex * f + i];
                sum += (w >> (8 * c)) & 8'hFF;
            end
        cnt = f * f;
        return (sum + cnt / 2) / cnt;
    endfunction

    function automatic int unsigned blend(int unsigned a, int unsigned b, int unsigned t);
        return (a * ((1 << FRAC) - t) + b * t + (1 << (FRAC - 1))) >> FRAC;
    endfunction

    function automatic scaled_pix_t scale_pixel(int unsigned col, int unsigned row);
        scaled_pix_t r;
        tap_geom_t   g;
        int unsigned ch [4];
        int unsigned top, bot;
        r = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
        if (col >= ((reg_dw == 0) ? 1 : reg_dw) || row >= ((reg_dh == 0) ? 1 : reg_dh)) begin
            r.oor = 1'b1;
            return r;
        end
        g = locate(col, row);
        for (int c = 0; c < 4; c++) begin
            top = blend(box_avg(g.x0, g.y0, g.f, c), box_avg(g.x1, g.y0, g.f, c), g.tx);
            bot = blend(box_avg(g.x0, g.y1, g.f, c), box_avg(g.x1, g.y1, g.f, c), g.tx);
            ch[c] = blend(top, bot, g.ty) & 8'hFF;
        end
        r.red   = 8'(ch[0]);
        r.green = 8'(ch[1]);
        r.blue  = 8'(ch[2]);
        r.alpha = (reg_ch == CHAN_RGBA) ? 8'(ch[3]) : 8'd0;
        return r;
    endfunction

    // queue a store and note what it will write
    task automatic push_store(int unsigned col, int unsigned row);
        pixel_cmd_t c;
        c.op    = OP_STORE;
        c.col   = 9'(col);
        c.row   = 9'(row);
        c.red   = 8'($urandom);
        c.green = 8'($urandom);
        c.blue  = 8'($urandom);
        c.alpha = 8'($urandom);
        if (col < eff_src(reg_sw, STORE_W) && row < eff_src(reg_sh, STORE_H))
            planned_written[row * STORE_W + col] = 1'b1;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // queue a read, first storing any source pixel it would touch that is still unwritten
    task automatic push_read(int unsigned col, int unsigned row);
        pixel_cmd_t  c;
        tap_geom_t   g;
        int unsigned fb, ex, ey, cx, cy;
        if (col < ((reg_dw == 0) ? 1 : reg_dw) && row < ((reg_dh == 0) ? 1 : reg_dh)) begin
            g  = locate(col, row);
            fb = (g.f < 2) ? 1 : g.f;
            for (int k = 0; k < 4; k++) begin
                ex = k[0] ? g.x1 : g.x0;
                ey = k[1] ? g.y1 : g.y0;
                for (int j = 0; j < fb; j++)
                    for (int i = 0; i < fb; i++) begin
                        cx = ex * fb + i;
                        cy = ey * fb + j;
                        if (!planned_written[cy * STORE_W + cx])
                            push_store(cx, cy);
                    end
            end
        end
        c = '{OP_READ, col[8:0], row[8:0], 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom)};
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_SRC_WIDTH:  reg_sw = val & 10'h3FF;
            CFG_SRC_HEIGHT: reg_sh = val & 10'h3FF;
            CFG_DST_WIDTH:  reg_dw = val & 10'h3FF;
            CFG_DST_HEIGHT: reg_dh = val & 10'h3FF;
            CFG_CHANNELS:   reg_ch = val & 3'h7;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                                int unsigned dh, int unsigned ch);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_CHANNELS, ch);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random mix: mostly in-range reads and in-source stores, some noise
    task automatic random_mix(int unsigned n);
        int unsigned sel, dw, dh, sw, sh;
        dw = (reg_dw == 0) ? 1 : ((reg_dw > 512) ? 512 : reg_dw);
        dh = (reg_dh == 0) ? 1 : ((reg_dh > 512) ? 512 : reg_dh);
        sw = eff_src(reg_sw, STORE_W);
        sh = eff_src(reg_sh, STORE_H);
        for (int n_done = 0; n_done < n; n_done++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                push_read($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
            else if (sel < 46)
                push_read($urandom_range(0, 511), $urandom_range(0, 511));
            else if (sel < 88)
                push_store($urandom_range(0, sw - 1), $urandom_range(0, sh - 1));
            else
                push_store($urandom_range(0, 511), $urandom_range(0, 511));
        end
    endtask

    // let the queued beats drain and the block go idle
    task automatic drain;
        wait (pending_cmds.size() == 0 && !i_valid && expected_pix.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        err_cnt++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        pixel_cmd_t c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                if (i_op == OP_READ) begin
                    expected_pix.insert(expected_pix.size(), scale_pixel(i_col, i_row));
                end else if (i_col < eff_src(reg_sw, STORE_W) &&
                             i_row < eff_src(reg_sh, STORE_H)) begin
                    frame_copy[i_row * STORE_W + i_col] =
                        {i_alpha_in, i_blue_in, i_green_in, i_red_in};
                end
            end
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                i_valid    <= 1'b1;
                i_op       <= c.op;
                i_col      <= c.col;
                i_row      <= c.row;
                i_red_in   <= c.red;
                i_green_in <= c.green;
                i_blue_in  <= c.blue;
                i_alpha_in <= c.alpha;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        scaled_pix_t w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_pix.size() == 0) begin
                    $display("result beat with nothing expected at %0t", $realtime);
                    err_cnt++;
                end else begin
                    w = expected_pix.pop_front();
                    if (o_red_out !== w.red)   report_mismatch("red", o_red_out, w.red);
                    if (o_green_out !== w.green) report_mismatch("green", o_green_out, w.green);
                    if (o_blue_out !== w.blue) report_mismatch("blue", o_blue_out, w.blue);
                    if (o_alpha_out !== w.alpha) report_mismatch("alpha", o_alpha_out, w.alpha);
                    if (o_out_of_range !== w.oor)
                        report_mismatch("out_of_range", o_out_of_range, w.oor);
                end
            end
            if (hold_ack_seq != hold_req_seq) begin
                hold_ack_seq <= hold_req_seq;
                hold_left    <= HOLD_LEN;
                i_ready      <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_MAX) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: upscale 128 to 512, no prefilter
        send_idle_pct = 30;
        recv_idle_pct = 56;
        random_mix(60);
        drain();

        // directed: extremes, ignored stores, out-of-range reads, factor 4 rgba
        set_geometry(16, 16, 4, 4, CHAN_RGBA);
        pending_cmds.insert(pending_cmds.size(),
                            '{OP_STORE, 9'd15, 9'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        pending_cmds.insert(pending_cmds.size(),
                            '{OP_STORE, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00, 8'h00});
        pending_cmds.insert(pending_cmds.size(),
                            '{OP_STORE, 9'd511, 9'd511, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        pending_cmds.insert(pending_cmds.size(),
                            '{OP_STORE, 9'd16, 9'd0, 8'hAA, 8'h55, 8'hAA, 8'h55});
        pending_cmds.insert(pending_cmds.size(),
                            '{OP_STORE, 9'd0, 9'd16, 8'h55, 8'hAA, 8'h55, 8'hAA});
        planned_written[15 * STORE_W + 15] = 1'b1;
        planned_written[0] = 1'b1;
        push_read(0, 0);
        push_read(3, 3);
        push_read(3, 0);
        push_read(0, 3);
        push_read(4, 0);
        push_read(0, 4);
        push_read(511, 511);
        push_read(256, 1);
        // long receiver stall while reads keep coming
        hold_req_seq++;
        random_mix(40);
        drain();

        // widest source, factor 2 along a single effective row
        set_geometry(512, 2, 1, 1, CHAN_RGBA);
        random_mix(40);
        drain();

        send_idle_pct = 56;
        recv_idle_pct = 30;
        // zero sizes collapse to one pixel, a channel count other than 4 means rgb
        set_geometry(0, 0, 0, 0, 7);
        random_mix(40);
        drain();

        set_geometry(24, 20, 7, 9, CHAN_RGBA);
        random_mix(60);
        drain();

        // oversized source registers saturate, single source pixel stretched wide
        set_geometry(1023, 1023, 1023, 1023, 3);
        random_mix(60);
        drain();
        set_geometry(1, 1, 512, 512, CHAN_RGBA);
        random_mix(40);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // larger box factor, kept short
        set_geometry(20, 20, 4, 4, 3);
        random_mix(40);
        drain();

        set_geometry(10, 12, 10, 12, CHAN_RGBA);
        random_mix(100);
        drain();

        set_geometry(9, 5, 13, 3, CHAN_RGBA);
        random_mix(100);
        drain();

        set_geometry(20, 18, 9, 8, 3);
        random_mix(100);
        drain();

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
